### rtl/ars_pkg.sv
package ars_pkg;

	localparam int DEF_MAX_OPERATORS = 8;

	localparam int W_W    = 24;
	localparam int SCR_W  = 40;
	localparam int USE_W  = 16;
	localparam int R_W    = 17;
	localparam int CNT_W  = 8;
	localparam int ACC_W  = 30;
	localparam int TGT_W  = ACC_W + 16;
	localparam int FIDX_W = 6;
	localparam int DIV_STEPS = SCR_W;

	localparam logic [W_W-1:0]   ONE_Q16    = 24'd65536;
	localparam logic [W_W-1:0]   MIN_WEIGHT = 24'd655;
	localparam logic [W_W-1:0]   WEIGHT_MAX = 24'hFFFFFF;
	localparam logic [SCR_W-1:0] SCORE_MAX  = 40'hFF_FFFF_FFFF;
	localparam logic [USE_W-1:0] USES_MAX   = 16'hFFFF;

	localparam logic [1:0] OP_SELECT = 2'd0;
	localparam logic [1:0] OP_CREDIT = 2'd1;
	localparam logic [1:0] OP_FLUSH  = 2'd2;
	localparam logic [1:0] OP_LOAD   = 2'd3;

	localparam logic [1:0] OC_NEW_BEST = 2'd0;
	localparam logic [1:0] OC_IMPROVED = 2'd1;
	localparam logic [1:0] OC_ACCEPTED = 2'd2;
	localparam logic [1:0] OC_REJECTED = 2'd3;

	localparam logic [2:0] REG_OPERATOR_COUNT  = 3'd0;
	localparam logic [2:0] REG_REACTION        = 3'd1;
	localparam logic [2:0] REG_SEGMENT_LENGTH  = 3'd2;
	localparam logic [2:0] REG_REWARD_NEW_BEST = 3'd3;
	localparam logic [2:0] REG_REWARD_IMPROVED = 3'd4;
	localparam logic [2:0] REG_REWARD_ACCEPTED = 3'd5;
	localparam logic [2:0] REG_REWARD_REJECTED = 3'd6;

	typedef struct packed {
		logic             valid;
		logic             search;
		logic [ACC_W-1:0] acc;
		logic             found;
		logic [FIDX_W-1:0] fidx;
	} tok_t;

	typedef struct packed {
		logic           credit;
		logic           load;
		logic           start;
		logic [2:0]     idx;
		logic [W_W-1:0] reward;
		logic [W_W-1:0] wval;
	} cmd_t;

endpackage

### rtl/ars_req_if.sv
interface ars_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [15:0] draw;
	logic [2:0]  index;
	logic [1:0]  outcome;
	logic [23:0] weight_value;

	modport source(output valid, op, draw, index, outcome, weight_value, input ready);
	modport sink(input valid, op, draw, index, outcome, weight_value, output ready);
endinterface

### rtl/ars_rsp_if.sv
interface ars_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] chosen;
	logic       weights_updated;
	logic       status;

	modport source(output valid, chosen, weights_updated, status, input ready);
	modport sink(input valid, chosen, weights_updated, status, output ready);
endinterface

### rtl/ars_cell.sv
module ars_cell #(
	parameter int CELL_INDEX = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ars_pkg::cmd_t               cmd,
	input  logic [ars_pkg::CNT_W-1:0]   eff_cnt,
	input  logic [ars_pkg::R_W-1:0]     r_eff,
	input  logic [ars_pkg::TGT_W-1:0]   target,
	input  ars_pkg::tok_t               tok_in,
	output ars_pkg::tok_t               tok_out,
	output logic                        done
);

	localparam logic [ars_pkg::CNT_W-1:0]  MY_CNT  = CELL_INDEX[ars_pkg::CNT_W-1:0];
	localparam logic [2:0]                 MY_IDX  = CELL_INDEX[2:0];
	localparam logic [ars_pkg::FIDX_W-1:0] MY_FIDX = CELL_INDEX[ars_pkg::FIDX_W-1:0];
	localparam bit                         ADDRESSABLE = CELL_INDEX < 8;
	localparam logic [5:0] STEPS = ars_pkg::DIV_STEPS[5:0];

	logic [ars_pkg::W_W-1:0]   w_q;
	logic [ars_pkg::SCR_W-1:0] score_q;
	logic [ars_pkg::USE_W-1:0] uses_q;
	ars_pkg::tok_t             tok_q;

	logic [5:0]                  cnt_q;
	logic                        mul_q, wr_q, done_q, run_q;
	logic [ars_pkg::USE_W:0]     rem_q;
	logic [ars_pkg::SCR_W-1:0]   quo_q;
	logic [40:0]                 p1_s1, p2_s1;

	logic                        active, hit_me;
	logic [ars_pkg::ACC_W-1:0]   cum_new;
	logic [ars_pkg::USE_W:0]     rem_sh;
	logic                        q_bit;
	logic [ars_pkg::W_W-1:0]     avg;
	logic [41:0]                 mix;
	logic [25:0]                 mix_sh;
	logic [ars_pkg::W_W-1:0]     w_new;
	logic [ars_pkg::SCR_W:0]     score_sum;

	assign active = MY_CNT < eff_cnt;
	assign hit_me = ADDRESSABLE && (cmd.idx == MY_IDX);

	// search chain: running sum of active weights moves one cell per cycle
	assign cum_new = active ? tok_in.acc + {{(ars_pkg::ACC_W-ars_pkg::W_W){1'b0}}, w_q}
	                        : tok_in.acc;

	assign rem_sh = {rem_q[ars_pkg::USE_W-1:0], quo_q[ars_pkg::SCR_W-1]};
	assign q_bit  = rem_sh >= {1'b0, uses_q};

	assign avg = (quo_q[ars_pkg::SCR_W-1:ars_pkg::W_W] != '0) ? ars_pkg::WEIGHT_MAX
	                                                         : quo_q[ars_pkg::W_W-1:0];

	assign mix    = {1'b0, p1_s1} + {1'b0, p2_s1} + 42'd32768;
	assign mix_sh = mix[41:16];
	always_comb begin
		if (mix_sh > {2'b0, ars_pkg::WEIGHT_MAX}) begin
			w_new = ars_pkg::WEIGHT_MAX;
		end else if (mix_sh[ars_pkg::W_W-1:0] < ars_pkg::MIN_WEIGHT) begin
			w_new = ars_pkg::MIN_WEIGHT;
		end else begin
			w_new = mix_sh[ars_pkg::W_W-1:0];
		end
	end

	assign score_sum = {1'b0, score_q} + {17'b0, cmd.reward};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.valid  <= tok_in.valid;
			tok_q.search <= tok_in.search;
			tok_q.acc    <= cum_new;
			if (tok_in.search && !tok_in.found && active
			    && (target <= {cum_new, 16'b0})) begin
				tok_q.found <= 1'b1;
				tok_q.fidx  <= MY_FIDX;
			end else begin
				tok_q.found <= tok_in.found;
				tok_q.fidx  <= tok_in.fidx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			mul_q  <= 1'b0;
			wr_q   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			mul_q  <= cnt_q == 6'd1;
			wr_q   <= mul_q;
			done_q <= wr_q;
			if (cmd.start) begin
				cnt_q <= STEPS;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	// restoring divide, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= '0;
			quo_q <= score_q;
			run_q <= active && (uses_q != '0);
		end else if (cnt_q != '0) begin
			rem_q <= q_bit ? rem_sh - {1'b0, uses_q} : rem_sh;
			quo_q <= {quo_q[ars_pkg::SCR_W-2:0], q_bit};
		end
		if (mul_q) begin
			p1_s1 <= {24'b0, 17'd65536 - r_eff} * {17'b0, w_q};
			p2_s1 <= {24'b0, r_eff} * {17'b0, avg};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q     <= ars_pkg::ONE_Q16;
			score_q <= '0;
			uses_q  <= '0;
		end else if (wr_q) begin
			if (run_q) begin
				w_q <= w_new;
			end
			score_q <= '0;
			uses_q  <= '0;
		end else if (cmd.credit && hit_me) begin
			score_q <= score_sum[ars_pkg::SCR_W] ? ars_pkg::SCORE_MAX
			                                     : score_sum[ars_pkg::SCR_W-1:0];
			if (uses_q != ars_pkg::USES_MAX) begin
				uses_q <= uses_q + 16'd1;
			end
		end else if (cmd.load && hit_me) begin
			w_q     <= (cmd.wval == '0) ? ars_pkg::ONE_Q16 : cmd.wval;
			score_q <= '0;
			uses_q  <= '0;
		end
	end

	assign tok_out = tok_q;
	assign done    = done_q;

	a_tok_mode_steady: assert property (@(posedge clk) disable iff (!arst_n)
		tok_in.valid |=> tok_q.valid && (tok_q.search == $past(tok_in.search)))
		else $error("token lost in cell");
	a_no_credit_during_update: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0 || mul_q || wr_q) |-> !(cmd.credit || cmd.load))
		else $error("tally write during update");
	a_done_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(wr_q))
		else $error("done without write");

endmodule

### rtl/adaptive_roulette_selector.sv
// Select: the token walks the cell row twice (weight sum, then cumulative search)
// with one multiply between.
// Credit and load_weight go straight to the result; a credit or flush that closes a
// segment first runs the per-cell 40-step restoring divider and multiply stage.
// One item is in work at a time; the result register frees the input side.
// Asynchronous active-low reset: weights 1.0, tallies zero, registers at defaults.
module adaptive_roulette_selector #(
	parameter int MAX_OPERATORS = ars_pkg::DEF_MAX_OPERATORS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	ars_req_if.sink     req,
	ars_rsp_if.source   rsp
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SUM  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_SRCH = 3'd3;
	localparam logic [2:0] ST_ARM  = 3'd4;
	localparam logic [2:0] ST_UPD  = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	localparam logic [ars_pkg::CNT_W-1:0] MAX_CNT = MAX_OPERATORS[ars_pkg::CNT_W-1:0];

	logic [3:0]  op_count_q;
	logic [16:0] reaction_q;
	logic [15:0] seg_len_q;
	logic [23:0] rw_best_q, rw_impr_q, rw_acc_q, rw_rej_q;

	logic [2:0]  state_q;
	logic [15:0] credits_q;
	logic [15:0] draw_q;
	logic        inj_q, srch_q;
	logic [ars_pkg::ACC_W-1:0] sum_q;
	logic [ars_pkg::TGT_W-1:0] target_q;
	ars_pkg::cmd_t cmd_q;

	logic       res_chosen_q, res_dummy;
	logic [2:0] res_idx_q;
	logic       res_upd_q, res_stat_q;
	logic       out_valid_q;
	logic [2:0] out_chosen_q;
	logic       out_upd_q, out_stat_q;

	logic [ars_pkg::CNT_W-1:0] eff_cnt, last_idx;
	logic [16:0]   r_eff;
	logic [15:0]   len_eff, credits_inc;
	logic [23:0]   reward;
	logic          accept, bad_idx, wr_cfg;
	ars_pkg::tok_t tok_v [MAX_OPERATORS+1];
	logic [MAX_OPERATORS-1:0] done_v;

	assign res_dummy = res_chosen_q;

	always_comb begin
		if (op_count_q == 4'd0) begin
			eff_cnt = 8'd1;
		end else if ({4'b0, op_count_q} > MAX_CNT) begin
			eff_cnt = MAX_CNT;
		end else begin
			eff_cnt = {4'b0, op_count_q};
		end
	end
	assign last_idx    = eff_cnt - 8'd1;
	assign r_eff       = (reaction_q > 17'd65536) ? 17'd65536 : reaction_q;
	assign len_eff     = (seg_len_q == 16'd0) ? 16'd1 : seg_len_q;
	assign credits_inc = (credits_q == ars_pkg::USES_MAX) ? credits_q : credits_q + 16'd1;
	assign bad_idx     = {5'b0, req.index} >= eff_cnt;

	always_comb begin
		case (req.outcome)
			ars_pkg::OC_NEW_BEST: reward = rw_best_q;
			ars_pkg::OC_IMPROVED: reward = rw_impr_q;
			ars_pkg::OC_ACCEPTED: reward = rw_acc_q;
			default:              reward = rw_rej_q;
		endcase
	end

	// configuration port
	assign pready = 1'b1;
	assign wr_cfg = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_count_q <= 4'd1;
			reaction_q <= 17'd6554;
			seg_len_q  <= 16'd100;
			rw_best_q  <= 24'd524288;
			rw_impr_q  <= 24'd262144;
			rw_acc_q   <= 24'd131072;
			rw_rej_q   <= 24'd32768;
		end else if (wr_cfg) begin
			case (paddr[4:2])
				ars_pkg::REG_OPERATOR_COUNT:  op_count_q <= pwdata[3:0];
				ars_pkg::REG_REACTION:        reaction_q <= pwdata[16:0];
				ars_pkg::REG_SEGMENT_LENGTH:  seg_len_q  <= pwdata[15:0];
				ars_pkg::REG_REWARD_NEW_BEST: rw_best_q  <= pwdata[23:0];
				ars_pkg::REG_REWARD_IMPROVED: rw_impr_q  <= pwdata[23:0];
				ars_pkg::REG_REWARD_ACCEPTED: rw_acc_q   <= pwdata[23:0];
				ars_pkg::REG_REWARD_REJECTED: rw_rej_q   <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			ars_pkg::REG_OPERATOR_COUNT:  prdata = {28'b0, op_count_q};
			ars_pkg::REG_REACTION:        prdata = {15'b0, reaction_q};
			ars_pkg::REG_SEGMENT_LENGTH:  prdata = {16'b0, seg_len_q};
			ars_pkg::REG_REWARD_NEW_BEST: prdata = {8'b0, rw_best_q};
			ars_pkg::REG_REWARD_IMPROVED: prdata = {8'b0, rw_impr_q};
			ars_pkg::REG_REWARD_ACCEPTED: prdata = {8'b0, rw_acc_q};
			ars_pkg::REG_REWARD_REJECTED: prdata = {8'b0, rw_rej_q};
			default:                      prdata = 32'b0;
		endcase
	end

	// cell row
	assign tok_v[0] = '{valid: inj_q, search: srch_q, acc: '0, found: 1'b0, fidx: '0};

	for (genvar i = 0; i < MAX_OPERATORS; i++) begin : g_cell
		ars_cell #(.CELL_INDEX(i)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd_q),
			.eff_cnt (eff_cnt),
			.r_eff   (r_eff),
			.target  (target_q),
			.tok_in  (tok_v[i]),
			.tok_out (tok_v[i+1]),
			.done    (done_v[i])
		);
	end

	assign req.ready = state_q == ST_IDLE;
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk) begin
		if (accept) begin
			draw_q <= req.draw;
		end
		if (state_q == ST_SUM && tok_v[MAX_OPERATORS].valid) begin
			sum_q <= tok_v[MAX_OPERATORS].acc;
		end
		if (state_q == ST_MUL) begin
			target_q <= {30'b0, draw_q} * {16'b0, sum_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			credits_q    <= '0;
			inj_q        <= 1'b0;
			srch_q       <= 1'b0;
			cmd_q        <= '0;
			res_chosen_q <= 1'b0;
			res_idx_q    <= '0;
			res_upd_q    <= 1'b0;
			res_stat_q   <= 1'b0;
		end else begin
			inj_q       <= 1'b0;
			cmd_q.credit <= 1'b0;
			cmd_q.load   <= 1'b0;
			cmd_q.start  <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_idx_q    <= '0;
						res_upd_q    <= 1'b0;
						res_stat_q   <= 1'b0;
						res_chosen_q <= 1'b0;
						cmd_q.idx    <= req.index;
						cmd_q.reward <= reward;
						cmd_q.wval   <= req.weight_value;
						case (req.op)
							ars_pkg::OP_SELECT: begin
								inj_q   <= 1'b1;
								srch_q  <= 1'b0;
								state_q <= ST_SUM;
							end
							ars_pkg::OP_FLUSH: begin
								state_q <= (credits_q != '0) ? ST_ARM : ST_DONE;
							end
							default: begin
								if (bad_idx) begin
									res_stat_q <= 1'b1;
									state_q    <= ST_DONE;
								end else if (req.op == ars_pkg::OP_CREDIT) begin
									cmd_q.credit <= 1'b1;
									credits_q    <= credits_inc;
									state_q      <= (credits_inc >= len_eff) ? ST_ARM
									                                          : ST_DONE;
								end else begin
									cmd_q.load <= 1'b1;
									state_q    <= ST_DONE;
								end
							end
						endcase
					end
				end
				ST_SUM: begin
					if (tok_v[MAX_OPERATORS].valid) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					inj_q   <= 1'b1;
					srch_q  <= 1'b1;
					state_q <= ST_SRCH;
				end
				ST_SRCH: begin
					if (tok_v[MAX_OPERATORS].valid) begin
						res_chosen_q <= 1'b1;
						res_idx_q    <= tok_v[MAX_OPERATORS].found
						                ? tok_v[MAX_OPERATORS].fidx[2:0] : last_idx[2:0];
						state_q      <= ST_DONE;
					end
				end
				ST_ARM: begin
					cmd_q.start <= 1'b1;
					state_q     <= ST_UPD;
				end
				ST_UPD: begin
					if (done_v[0]) begin
						credits_q <= '0;
						res_upd_q <= 1'b1;
						state_q   <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!out_valid_q || rsp.ready)) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || rsp.ready)) begin
			out_chosen_q <= res_dummy ? res_idx_q : 3'd0;
			out_upd_q    <= res_upd_q;
			out_stat_q   <= res_stat_q;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.chosen          = out_chosen_q;
	assign rsp.weights_updated = out_upd_q;
	assign rsp.status          = out_stat_q;

	a_cells_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		(done_v == '0) || (&done_v))
		else $error("cells finished update out of step");
	a_done_in_update: assert property (@(posedge clk) disable iff (!arst_n)
		done_v[0] |-> state_q == ST_UPD)
		else $error("update done outside update state");
	a_token_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		tok_v[MAX_OPERATORS].valid |-> (state_q == ST_SUM || state_q == ST_SRCH))
		else $error("token left row outside a walk");
	a_credits_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD && done_v[0]) |=> credits_q == '0)
		else $error("segment count not cleared");

endmodule
